// ----- rtl/core/puvr_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// puvr_pkg
// Shared types and constants of the patch uv remap unit.
// ---------------------------------------------------------------------------
package puvr_pkg;

   localparam int MAX_PATCHES_DEF = 64;
   localparam int RECT_W          = 128;
   localparam int CSR_W           = 7;
   localparam int FRAC_W          = 17;   // fraction in [0, 1.0] Q1.16
   localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_MAP   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_MISS   = 2'd1,
      STS_ZERO_U = 2'd2,
      STS_ZERO_V = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_PATCHED = 2'd0,
      CSR_PU      = 2'd1,
      CSR_PV      = 2'd2,
      CSR_NONE    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_DIV_U,
      ST_DIV_V,
      ST_DONE
   } fsm_state_type;

endpackage : puvr_pkg
`default_nettype wire

// ----- rtl/core/puvr_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// puvr request / response channels
// Valid-ready channels carrying one word per handshake.
// ---------------------------------------------------------------------------
interface puvr_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [5:0]         entry_index;
   logic signed [31:0] patch_u_start;
   logic signed [31:0] patch_u_end;
   logic signed [31:0] patch_v_start;
   logic signed [31:0] patch_v_end;
   logic signed [31:0] point_u;
   logic signed [31:0] point_v;

   modport source (output valid, op, entry_index, patch_u_start, patch_u_end,
                   patch_v_start, patch_v_end, point_u, point_v, input ready);
   modport sink   (input valid, op, entry_index, patch_u_start, patch_u_end,
                   patch_v_start, patch_v_end, point_u, point_v, output ready);
endinterface : puvr_req_if

interface puvr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] mapped_u;
   logic signed [31:0] mapped_v;

   modport source (output valid, status, mapped_u, mapped_v, input ready);
   modport sink   (input valid, status, mapped_u, mapped_v, output ready);
endinterface : puvr_rsp_if
`default_nettype wire

// ----- rtl/core/puvr_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// puvr_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module puvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule : puvr_ram
`default_nettype wire

// ----- rtl/core/puvr_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// puvr_div
// Bit-serial span fraction: (diff << 16) / den, with diff <= den, den != 0.
// ---------------------------------------------------------------------------
module puvr_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] diff,
   input  wire logic [31:0] den,
   output logic             done,
   output logic [puvr_pkg::FRAC_W-1:0] quo
);

   localparam int CW = $clog2(puvr_pkg::FRAC_W + 1);

   logic                        busy_ff, busy_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [31:0]                 rem_ff, rem_in;
   logic [puvr_pkg::FRAC_W-1:0] sh_ff, sh_in;
   logic [puvr_pkg::FRAC_W-1:0] quo_ff, quo_in;
   logic [31:0]                 den_ff, den_in;
   logic [32:0]                 trial;

   // quotient bits above bit 16 are zero since diff <= den, so the
   // remainder starts at diff >> 1 and only 17 steps remain
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, sh_ff[puvr_pkg::FRAC_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(puvr_pkg::FRAC_W);
         rem_in  = {1'b0, diff[31:1]};
         sh_in   = {diff[0], {(puvr_pkg::FRAC_W-1){1'b0}}};
         quo_in  = '0;
         den_in  = den;
      end else if (busy_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         sh_in  = {sh_ff[puvr_pkg::FRAC_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[puvr_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[puvr_pkg::FRAC_W-2:0], 1'b0};
         end
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = busy_ff && (cnt_ff == '0);
   assign quo  = quo_ff;

endmodule : puvr_div
`default_nettype wire

// ----- rtl/core/patch_uv_remap_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// patch_uv_remap_unit
// Patch table lookup: maps a global Q16.16 (u,v) point to patch row/column
// plus the fraction along the containing patch's spans.
// ---------------------------------------------------------------------------
// Sequence: a write word or an unpatched map word goes from IDLE through DONE
//   into the output register. A patched map scans the entries, one RAM read per
//   cycle, then checks the hit, runs u then v through the shared bit-serial
//   divider, and passes through DONE into the output register.
// Throughput: one word at a time; the next word is taken once the result
//   has moved into the output register.
// Reset: synchronous, active high; clears control state and the registers to
//   unpatched, 1 x 1 patches. The patch RAM is not cleared.
module patch_uv_remap_unit #(
   parameter int MAX_PATCHES = puvr_pkg::MAX_PATCHES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   puvr_req_if.sink                       req_ch,
   puvr_rsp_if.source                     rsp_ch,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [puvr_pkg::CSR_W-1:0] csr_wdata
);

   localparam int AW = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
   localparam int IW = $clog2(MAX_PATCHES + 1);

   // ---- configuration registers ----
   logic       patched_ff;
   logic [6:0] pu_ff;
   logic [6:0] pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         patched_ff <= 1'b0;
         pu_ff      <= 7'd1;
         pv_ff      <= 7'd1;
      end else if (csr_we) begin
         unique case (puvr_pkg::csr_index_type'(csr_index))
            puvr_pkg::CSR_PATCHED: patched_ff <= csr_wdata[0];
            puvr_pkg::CSR_PU:      pu_ff      <= csr_wdata;
            puvr_pkg::CSR_PV:      pv_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- state ----
   puvr_pkg::fsm_state_type state_ff, state_in;

   logic                     accept;
   logic                     out_load;
   logic                     ram_we;
   logic                     ram_re;
   logic [puvr_pkg::RECT_W-1:0] ram_rdata;
   logic                     div_start;
   logic                     div_done;
   logic [puvr_pkg::FRAC_W-1:0] div_quo;
   logic [31:0]              div_diff;
   logic [31:0]              div_den;

   // scan issue side: next entry to read
   logic [6:0]    ir_ff, ic_ff;
   logic [IW-1:0] iidx_ff;
   logic          ion_ff;
   logic          last_issue;
   // scan compare side: entry whose data sits on the RAM output
   logic          pend_ff;
   logic [6:0]    pr_ff, pc_ff;
   logic          hit;

   // captured word and hit rectangle
   logic signed [31:0] pu_pt_ff, pv_pt_ff;
   logic signed [31:0] us_ff, ue_ff, vs_ff, ve_ff;
   logic [6:0]         hr_ff, hc_ff;
   logic [puvr_pkg::FRAC_W-1:0] fu_ff;

   // result waiting for the output register
   logic [1:0]         res_sts_ff;
   logic signed [31:0] res_u_ff, res_v_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_sts_ff;
   logic signed [31:0] rsp_u_ff, rsp_v_ff;

   logic signed [31:0] ram_us, ram_ue, ram_vs, ram_ve;
   logic signed [32:0] off_u, off_v;

   assign ram_us = $signed(ram_rdata[127:96]);
   assign ram_ue = $signed(ram_rdata[95:64]);
   assign ram_vs = $signed(ram_rdata[63:32]);
   assign ram_ve = $signed(ram_rdata[31:0]);

   assign accept = req_ch.valid && req_ch.ready;

   // bounds inclusive
   assign hit = pend_ff && (pu_pt_ff >= ram_us) && (pu_pt_ff <= ram_ue)
                        && (pv_pt_ff >= ram_vs) && (pv_pt_ff <= ram_ve);

   // last read: end of last row, or end of the table
   assign last_issue = ((8'(ic_ff) + 8'd1 == 8'(pv_ff)) && (8'(ir_ff) + 8'd1 == 8'(pu_ff)))
                       || (32'(iidx_ff) + 32'd1 == 32'(MAX_PATCHES));

   // minus 1.0, saturating at the bottom of the range
   assign off_u = {req_ch.point_u[31], req_ch.point_u} - puvr_pkg::ONE_Q16;
   assign off_v = {req_ch.point_v[31], req_ch.point_v} - puvr_pkg::ONE_Q16;

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         puvr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_ch.op == puvr_pkg::OP_MAP && req_ch.op != 1'b0 && patched_ff
                   && pu_ff != '0 && pv_ff != '0) begin
                  state_in = puvr_pkg::ST_SCAN;
               end else begin
                  state_in = puvr_pkg::ST_DONE;
               end
            end
         end
         puvr_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = puvr_pkg::ST_CHECK;
            end else if (!ion_ff && !pend_ff) begin
               state_in = puvr_pkg::ST_DONE;
            end
         end
         puvr_pkg::ST_CHECK: begin
            if (us_ff == ue_ff || vs_ff == ve_ff) begin
               state_in = puvr_pkg::ST_DONE;
            end else begin
               state_in = puvr_pkg::ST_DIV_U;
            end
         end
         puvr_pkg::ST_DIV_U: begin
            if (div_done) begin
               state_in = puvr_pkg::ST_DIV_V;
            end
         end
         puvr_pkg::ST_DIV_V: begin
            if (div_done) begin
               state_in = puvr_pkg::ST_DONE;
            end
         end
         puvr_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = puvr_pkg::ST_IDLE;
            end
         end
         default: state_in = puvr_pkg::ST_IDLE;
      endcase
   end

   // ---- outputs of the controller ----
   always_comb begin
      req_ch.ready = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         puvr_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            // writes beyond the table are dropped
            ram_we = accept && (req_ch.op == puvr_pkg::OP_WRITE)
                     && (32'(req_ch.entry_index) < 32'(MAX_PATCHES));
         end
         puvr_pkg::ST_SCAN: begin
            ram_re = ion_ff && !hit;
         end
         puvr_pkg::ST_CHECK: begin
            div_start = !(us_ff == ue_ff || vs_ff == ve_ff);
         end
         puvr_pkg::ST_DIV_U: begin
            div_start = div_done;
         end
         puvr_pkg::ST_DONE: begin
            out_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: ;
      endcase
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= puvr_pkg::ST_IDLE;
         ion_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == puvr_pkg::ST_IDLE) begin
            ion_ff  <= 1'b1;
            pend_ff <= 1'b0;
         end else if (state_ff == puvr_pkg::ST_SCAN) begin
            ion_ff  <= ion_ff && !hit && !last_issue;
            pend_ff <= ram_re;
         end else begin
            ion_ff  <= 1'b0;
            pend_ff <= 1'b0;
         end
      end
   end

   // ---- datapath ----
   always_ff @(posedge clock) begin
      if (state_ff == puvr_pkg::ST_IDLE) begin
         ir_ff    <= '0;
         ic_ff    <= '0;
         iidx_ff  <= '0;
         pu_pt_ff <= req_ch.point_u;
         pv_pt_ff <= req_ch.point_v;
         res_sts_ff <= puvr_pkg::STS_OK;
         res_u_ff   <= '0;
         res_v_ff   <= '0;
         if (req_ch.op == puvr_pkg::OP_MAP && !patched_ff) begin
            res_u_ff <= (off_u[32] != off_u[31]) ? 32'sh8000_0000 : off_u[31:0];
            res_v_ff <= (off_v[32] != off_v[31]) ? 32'sh8000_0000 : off_v[31:0];
         end else if (req_ch.op == puvr_pkg::OP_MAP) begin
            res_sts_ff <= puvr_pkg::STS_MISS;
         end
      end
      if (ram_re) begin
         pr_ff   <= ir_ff;
         pc_ff   <= ic_ff;
         iidx_ff <= iidx_ff + 1'b1;
         if (8'(ic_ff) + 8'd1 == 8'(pv_ff)) begin
            ic_ff <= '0;
            ir_ff <= ir_ff + 1'b1;
         end else begin
            ic_ff <= ic_ff + 1'b1;
         end
      end
      if (state_ff == puvr_pkg::ST_SCAN && hit) begin
         us_ff <= ram_us;
         ue_ff <= ram_ue;
         vs_ff <= ram_vs;
         ve_ff <= ram_ve;
         hr_ff <= pr_ff;
         hc_ff <= pc_ff;
      end
      if (state_ff == puvr_pkg::ST_CHECK) begin
         if (us_ff == ue_ff) begin
            res_sts_ff <= puvr_pkg::STS_ZERO_U;
         end else if (vs_ff == ve_ff) begin
            res_sts_ff <= puvr_pkg::STS_ZERO_V;
         end
      end
      if (state_ff == puvr_pkg::ST_DIV_U && div_done) begin
         fu_ff <= div_quo;
      end
      if (state_ff == puvr_pkg::ST_DIV_V && div_done) begin
         res_sts_ff <= puvr_pkg::STS_OK;
         res_u_ff   <= 32'({hr_ff, 16'h0000}) + 32'(fu_ff);
         res_v_ff   <= 32'({hc_ff, 16'h0000}) + 32'(div_quo);
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_sts_ff <= res_sts_ff;
         rsp_u_ff   <= res_u_ff;
         rsp_v_ff   <= res_v_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_sts_ff;
   assign rsp_ch.mapped_u = rsp_u_ff;
   assign rsp_ch.mapped_v = rsp_v_ff;

   // ---- patch table ----
   // writes happen only in IDLE and reads only in SCAN, so no forwarding
   puvr_ram #(
      .WIDTH (puvr_pkg::RECT_W),
      .DEPTH (MAX_PATCHES)
   ) u_rects (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(req_ch.entry_index)),
      .wdata ({req_ch.patch_u_start, req_ch.patch_u_end,
               req_ch.patch_v_start, req_ch.patch_v_end}),
      .re    (ram_re),
      .raddr (iidx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   // ---- shared span divider, u then v ----
   assign div_diff = (state_ff == puvr_pkg::ST_CHECK) ? 32'(pu_pt_ff - us_ff)
                                                      : 32'(pv_pt_ff - vs_ff);
   assign div_den  = (state_ff == puvr_pkg::ST_CHECK) ? 32'(ue_ff - us_ff)
                                                      : 32'(ve_ff - vs_ff);

   puvr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .diff  (div_diff),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---- checks ----
   a_we_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == puvr_pkg::ST_IDLE)
      else $error("table write outside idle");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == puvr_pkg::ST_SCAN)
      else $error("pending read outside scan");

   a_write_done: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.op == puvr_pkg::OP_WRITE) |=> state_ff == puvr_pkg::ST_DONE)
      else $error("write word did not finish at once");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sts_ff != puvr_pkg::STS_OK)
         |-> (rsp_u_ff == '0 && rsp_v_ff == '0))
      else $error("error result carries nonzero point");

endmodule : patch_uv_remap_unit
`default_nettype wire
